// File: rtl/multi_slot_software_timer_unit_defines.svh
// Assertion macros for the multi-slot software timer unit.
// No dependencies; included by the files that carry assertions.
`ifndef MULTI_SLOT_SOFTWARE_TIMER_UNIT_DEFINES_SVH
`define MULTI_SLOT_SOFTWARE_TIMER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check that a property holds at every rising clock edge outside reset.
`define MSTU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("timer unit property failed");
// Check that an expression is never true outside reset.
`define MSTU_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("timer unit forbidden condition seen");
`else
`define MSTU_ASSERT(label, clk, rst, prop)
`define MSTU_NEVER(label, clk, rst, expr)
`endif

`endif

// File: rtl/mstu_pkg.sv
// Shared types and constants of the multi-slot software timer unit.
// No dependencies.
`default_nettype none

package mstu_pkg;

   localparam int DEFAULT_NUM_SLOTS = 16;
   localparam int SLOT_ID_W         = 4;
   localparam int TIME_W            = 64;
   localparam int TICKS_W           = 32;
   localparam int KIND_W            = 2;
   localparam int QUERY_W           = 8;

   typedef enum logic [1:0] {
      ACT_INIT  = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_TICK  = 2'd2,
      ACT_QUERY = 2'd3
   } action_type;

   localparam logic [KIND_W-1:0] KIND_ONESHOT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REPEAT   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PERIODIC = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      action_type           action;
      logic [TIME_W-1:0]    now_time;
      logic [TICKS_W-1:0]   timeout_ticks;
      logic [KIND_W-1:0]    timer_kind;
      logic [QUERY_W-1:0]   query_slot;
   } req_type;

   typedef struct packed {
      logic [SLOT_ID_W-1:0] slot_id;
      logic                 table_full;
      logic                 is_active;
      logic                 fired;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0]    deadline;
      logic [TICKS_W-1:0]   period;
      logic [KIND_W-1:0]    kind;
   } slot_entry_type;

endpackage

`default_nettype wire

// File: rtl/mstu_slot_ram.sv
// Slot table memory: deadline, period and kind of each timer slot.
// One write port, one read port with registered read data; uses mstu_pkg.
`default_nettype none

module mstu_slot_ram
   import mstu_pkg::*;
#(
   parameter int DEPTH  = DEFAULT_NUM_SLOTS,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire slot_entry_type    wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output slot_entry_type         rd_data
);

   slot_entry_type mem_ff [DEPTH];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/multi_slot_software_timer_unit.sv
// Multi-slot software timer unit: top level with control and active marks.
// Depends on mstu_pkg, mstu_slot_ram and the assertion macro header.
`default_nettype none

`include "multi_slot_software_timer_unit_defines.svh"

// A table of NUM_SLOTS timer slots, handed out in order and never freed.
// A request is a transfer at the rising edge where start is high and busy
// is low. Init, add and query leave busy low: the single result shows on
// rsp_data with rsp_valid high in the next cycle, so a new request can
// follow every cycle. A tick latches now_time and walks the used slots
// one per cycle through the single read port of the slot memory, with
// busy high through the walk and a final done state; with no slot handed
// out it leaves busy low like the other actions. Each fire of a tick is its
// own result, in slot order, with last set on the final one; a tick that
// fires nothing returns one result with only last set. Results are one
// cycle strobes that the receiver must take when they appear: there is no
// back-pressure on the result side. Periodic slots reload their deadline
// during the walk by writing back into the slot memory. No memory clear is
// needed after reset: only slots already written by an add are ever
// evaluated, and the active marks sit in flip-flops cleared by reset.
module multi_slot_software_timer_unit
   import mstu_pkg::*;
#(
   parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

   // Control and status registers.
   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]  next_slot_ff, next_slot_in;
   logic [TIME_W-1:0] latched_ff, latched_in;
   logic              active_ff [NUM_SLOTS];
   logic              active_in [NUM_SLOTS];
   logic              pend_ff, pend_in;
   logic [SLOT_W-1:0] pend_idx_ff, pend_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // Slot memory ports.
   logic              ram_we;
   logic [SLOT_W-1:0] ram_waddr;
   slot_entry_type    ram_wdata;
   logic [SLOT_W-1:0] ram_raddr;
   slot_entry_type    ram_rdata;

   logic accept;
   logic query_in_range;
   logic scan_hit;
   logic scan_last;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign query_in_range = ({1'b0, req_data.query_slot} < (QUERY_W + 1)'(NUM_SLOTS));
   assign scan_hit  = active_ff[scan_idx_ff] && (latched_ff >= ram_rdata.deadline);
   assign scan_last = ((CNT_W'(scan_idx_ff) + CNT_W'(1)) == next_slot_ff);

   mstu_slot_ram #(
      .DEPTH  (NUM_SLOTS),
      .ADDR_W (SLOT_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_slot_ff <= '0;
         latched_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            active_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         next_slot_ff <= next_slot_in;
         latched_ff   <= latched_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            active_ff[i] <= active_in[i];
         end
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      pend_idx_ff <= pend_idx_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      scan_idx_in  = scan_idx_ff;
      next_slot_in = next_slot_ff;
      latched_in   = latched_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         active_in[i] = active_ff[i];
      end
      ram_we    = 1'b0;
      ram_waddr = scan_idx_ff;
      ram_wdata = '0;
      // Prefetch the slot after the one under evaluation; slot 0 in other states.
      ram_raddr = (state_ff == ST_SCAN) ? (scan_idx_ff + SLOT_W'(1)) : '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.action)
                  ACT_INIT: begin
                     // Drop every active mark; keep the slot counter.
                     for (int i = 0; i < NUM_SLOTS; i++) begin
                        active_in[i] = 1'b0;
                     end
                     latched_in   = req_data.now_time;
                     rsp_valid_in = 1'b1;
                     rsp_in.last  = 1'b1;
                  end
                  ACT_ADD: begin
                     rsp_valid_in = 1'b1;
                     rsp_in.last  = 1'b1;
                     if (next_slot_ff == CNT_W'(NUM_SLOTS)) begin
                        rsp_in.table_full = 1'b1;
                     end else begin
                        ram_we             = 1'b1;
                        ram_waddr          = next_slot_ff[SLOT_W-1:0];
                        ram_wdata.deadline = latched_ff + TIME_W'(req_data.timeout_ticks);
                        ram_wdata.period   = req_data.timeout_ticks;
                        ram_wdata.kind     = req_data.timer_kind;
                        active_in[next_slot_ff[SLOT_W-1:0]] = 1'b1;
                        next_slot_in       = next_slot_ff + CNT_W'(1);
                        rsp_in.slot_id     = SLOT_ID_W'(next_slot_ff);
                     end
                  end
                  ACT_TICK: begin
                     latched_in = req_data.now_time;
                     pend_in    = 1'b0;
                     if (next_slot_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.last  = 1'b1;
                     end else begin
                        // Slot 0 is read at this edge; evaluate it next cycle.
                        scan_idx_in = '0;
                        state_in    = ST_SCAN;
                     end
                  end
                  ACT_QUERY: begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.last      = 1'b1;
                     rsp_in.is_active = query_in_range &&
                                        active_ff[req_data.query_slot[SLOT_W-1:0]];
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (scan_hit) begin
               // Hold each fire until the next one shows it was not the final one.
               if (pend_ff) begin
                  rsp_valid_in   = 1'b1;
                  rsp_in.fired   = 1'b1;
                  rsp_in.slot_id = SLOT_ID_W'(pend_idx_ff);
               end
               pend_in     = 1'b1;
               pend_idx_in = scan_idx_ff;
               case (ram_rdata.kind)
                  KIND_ONESHOT: begin
                     active_in[scan_idx_ff] = 1'b0;
                  end
                  KIND_PERIODIC: begin
                     ram_we             = 1'b1;
                     ram_waddr          = scan_idx_ff;
                     ram_wdata.deadline = latched_ff + TIME_W'(ram_rdata.period);
                     ram_wdata.period   = ram_rdata.period;
                     ram_wdata.kind     = ram_rdata.kind;
                  end
                  default: begin
                     // Repeating and unlisted kinds stay as they are.
                  end
               endcase
            end
            if (scan_last) begin
               state_in = ST_DONE;
            end else begin
               scan_idx_in = scan_idx_ff + SLOT_W'(1);
            end
         end

         ST_DONE: begin
            // Release the held fire as the final transfer, or report no fire.
            rsp_valid_in = 1'b1;
            rsp_in.last  = 1'b1;
            if (pend_ff) begin
               rsp_in.fired   = 1'b1;
               rsp_in.slot_id = SLOT_ID_W'(pend_idx_ff);
            end
            pend_in  = 1'b0;
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A final transfer only appears once the unit is idle again.
   `MSTU_ASSERT(a_last_when_idle, clock, reset,
      (rsp_valid_ff && rsp_ff.last) |-> (state_ff == ST_IDLE))
   // A non-final transfer only appears while a tick is still in progress.
   `MSTU_ASSERT(a_more_while_busy, clock, reset,
      (rsp_valid_ff && !rsp_ff.last) |-> (state_ff != ST_IDLE))
   // The walk never reaches a slot that was not handed out.
   `MSTU_ASSERT(a_scan_in_use, clock, reset,
      (state_ff == ST_SCAN) |-> (CNT_W'(scan_idx_ff) < next_slot_ff))
   // The slot counter never runs past the table.
   `MSTU_NEVER(a_slot_count_bound, clock, reset,
      next_slot_ff > CNT_W'(NUM_SLOTS))

endmodule

`default_nettype wire
